>>> design/elevator_look_controller_top_assert.svh
// assertion macros for the elevator car controller
// no dependencies; included by the top level
`ifndef ELEVATOR_LOOK_CONTROLLER_TOP_ASSERT_SVH
`define ELEVATOR_LOOK_CONTROLLER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication, disabled during reset
`define ELC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, disabled during reset
`define ELC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ELC_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define ELC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

>>> design/elc_pkg.sv
// shared codes and control/status types for the elevator car controller
// no dependencies
`timescale 1ns / 1ps

package elc_pkg;

  localparam int CMD_W   = 2;
  localparam int FLOOR_W = 6;
  localparam int PHASE_W = 3;
  localparam int DIR_W   = 2;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 8;

  // door / car phases
  localparam logic [PHASE_W-1:0] PH_OPEN    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_CLOSING = 3'd1;
  localparam logic [PHASE_W-1:0] PH_CLOSED  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_OPENING = 3'd3;
  localparam logic [PHASE_W-1:0] PH_UP      = 3'd4;
  localparam logic [PHASE_W-1:0] PH_DOWN    = 3'd5;

  // travel direction
  localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
  localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

  // input commands, also used as the held presence code
  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REQ     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SOMEONE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd3;
  localparam logic [CMD_W-1:0] PRES_NONE   = 2'd0;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] REG_TRAVEL  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_DOOR    = 3'd1;
  localparam logic [CFG_IW-1:0] REG_BLOCKED = 3'd2;
  localparam logic [CFG_IW-1:0] REG_ABOVE   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_BASE    = 3'd4;

  typedef struct packed {
    logic exec;
    logic scan_step;
    logic apply;
    logic load_out;
  } elc_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_done;
  } elc_stat_t;

endpackage

>>> design/elc_ctrl.sv
// sequencer for the elevator car controller: accept, floor scan, result push
// depends on elc_pkg
`timescale 1ns / 1ps

module elc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_can_load,
  input  elc_pkg::elc_stat_t stat,
  output elc_pkg::elc_cmd_t  cmd
);
  import elc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.exec   = 1'b1;
          state_next = stat.need_scan ? ST_SCAN : ST_PUSH;
        end
      end
      ST_SCAN: begin
        if (stat.scan_done) begin
          cmd.apply  = 1'b1;
          state_next = ST_PUSH;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_PUSH: begin
        if (out_can_load) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/elc_dp.sv
// datapath of the elevator car controller: car state, timers, config, LOOK scan
// depends on elc_pkg
`timescale 1ns / 1ps

module elc_dp #(
  parameter int LEVELS = 26,
  parameter int IW     = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  elc_pkg::elc_cmd_t                   cmd,
  output elc_pkg::elc_stat_t                  stat,
  input  logic [elc_pkg::CMD_W-1:0]           in_cmd,
  input  logic signed [elc_pkg::FLOOR_W-1:0]  in_floor,
  input  logic                                cfg_we,
  input  logic [elc_pkg::CFG_IW-1:0]          cfg_index,
  input  logic [elc_pkg::CFG_DW-1:0]          cfg_data,
  output logic signed [elc_pkg::FLOOR_W-1:0]  s_floor,
  output logic [elc_pkg::PHASE_W-1:0]         s_phase,
  output logic [elc_pkg::DIR_W-1:0]           s_dir,
  output logic                                s_alarm,
  output logic                                s_blocked,
  output logic [LEVELS-1:0]                   s_flags
);
  import elc_pkg::*;

  localparam int XW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam logic signed [IW-1:0] LV = IW'(LEVELS);
  localparam logic signed [IW-1:0] ONE = IW'(1);

  // car state
  logic [LEVELS-1:0]   flags, flags_next;
  logic signed [IW-1:0] floor_r, floor_next;
  logic signed [IW-1:0] target, target_next;
  logic [DIR_W-1:0]    dir_r, dir_next;
  logic [PHASE_W-1:0]  phase_r, phase_next;
  logic                blocked, blocked_next;
  logic                alarm, alarm_next;
  logic [CMD_W-1:0]    pres, pres_next;
  logic [7:0]          tc, tc_next;

  // configuration
  logic [3:0] travel_ticks;
  logic [3:0] door_ticks;
  logic [7:0] wait_ticks;
  logic [4:0] above;
  logic [2:0] base;

  // scan pointers
  logic signed [IW-1:0] hi_ptr, hi_ptr_next, lo_ptr, lo_ptr_next;
  logic hi_done, hi_done_next, lo_done, lo_done_next;
  logic hi_found, hi_found_next, lo_found, lo_found_next;

  logic signed [IW-1:0] base_x, lvl_sum, n_lv, car_idx, req_idx, step_floor;
  logic signed [IW-1:0] dist_hi, dist_lo, clr_idx;
  logic [7:0] tc_inc;
  logic       clr_en, need_scan, go_up, go_dn, lay_clear;

  assign base_x  = {{(IW-3){1'b0}}, base};
  assign lvl_sum = {{(IW-5){1'b0}}, above} + base_x + ONE;
  assign n_lv    = (lvl_sum > LV) ? LV : lvl_sum;
  assign car_idx = floor_r + base_x;
  assign req_idx = {{(IW-FLOOR_W){in_floor[FLOOR_W-1]}}, in_floor} + base_x;
  assign tc_inc  = (tc == 8'hff) ? tc : tc + 8'd1;
  assign step_floor = (floor_r < target) ? floor_r + ONE : floor_r - ONE;
  assign dist_hi = hi_ptr - car_idx;
  assign dist_lo = car_idx - lo_ptr;

  // LOOK choice from the finished scan
  always_comb begin
    go_up = 1'b0;
    go_dn = 1'b0;
    case (dir_r)
      DIR_UP: begin
        go_up = hi_found;
        go_dn = !hi_found && lo_found;
      end
      DIR_DOWN: begin
        go_dn = lo_found;
        go_up = !lo_found && hi_found;
      end
      default: begin
        if (hi_found && lo_found) begin
          go_up = (dist_hi <= dist_lo);
          go_dn = !(dist_hi <= dist_lo);
        end else begin
          go_up = hi_found;
          go_dn = lo_found;
        end
      end
    endcase
  end

  always_comb begin
    flags_next   = flags;
    floor_next   = floor_r;
    target_next  = target;
    dir_next     = dir_r;
    phase_next   = phase_r;
    blocked_next = blocked;
    alarm_next   = alarm;
    pres_next    = pres;
    tc_next      = tc;
    clr_en       = 1'b0;
    clr_idx      = car_idx;
    need_scan    = 1'b0;
    hi_ptr_next   = hi_ptr;
    lo_ptr_next   = lo_ptr;
    hi_done_next  = hi_done;
    lo_done_next  = lo_done;
    hi_found_next = hi_found;
    lo_found_next = lo_found;

    // outcome of the presented item, applied only on exec
    case (in_cmd)
      CMD_TICK: begin
        case (phase_r)
          PH_CLOSING: begin
            if (!alarm) begin
              tc_next = tc_inc;
              if (blocked) begin
                if (tc_inc >= wait_ticks) begin
                  tc_next = 8'd0;
                  if (pres == CMD_CLEAR) begin
                    blocked_next = 1'b0;
                    pres_next    = PRES_NONE;
                  end else if (pres == CMD_SOMEONE) begin
                    alarm_next = 1'b1;
                    pres_next  = PRES_NONE;
                  end
                end
              end else if (tc_inc >= {4'd0, door_ticks}) begin
                phase_next = PH_CLOSED;
                tc_next    = 8'd0;
                need_scan  = 1'b1;
              end
            end
          end
          PH_CLOSED: begin
            if (|flags) begin
              need_scan = 1'b1;
            end else begin
              phase_next = PH_OPENING;
              tc_next    = 8'd0;
            end
          end
          PH_OPENING: begin
            tc_next = tc_inc;
            if (tc_inc >= {4'd0, door_ticks}) begin
              phase_next = PH_OPEN;
              tc_next    = 8'd0;
            end
          end
          PH_UP, PH_DOWN: begin
            if (floor_r == target) begin
              clr_en     = 1'b1;
              phase_next = PH_OPENING;
              tc_next    = 8'd0;
            end else begin
              tc_next = tc_inc;
              if (tc_inc >= {4'd0, travel_ticks}) begin
                tc_next    = 8'd0;
                floor_next = step_floor;
                if (step_floor == target) begin
                  clr_en     = 1'b1;
                  clr_idx    = step_floor + base_x;
                  phase_next = PH_OPENING;
                end
              end
            end
          end
          default: begin
            phase_next = PH_OPEN;
            if (|flags) begin
              tc_next = tc_inc;
              if (tc_inc >= {4'd0, door_ticks}) begin
                // closing starts; a held presence blocks the door
                phase_next   = PH_CLOSING;
                tc_next      = 8'd0;
                blocked_next = (pres == CMD_SOMEONE);
                alarm_next   = 1'b0;
                pres_next    = PRES_NONE;
              end
            end else begin
              tc_next = 8'd0;
            end
          end
        endcase
      end
      CMD_REQ: begin
        if (req_idx >= 0 && req_idx < n_lv) begin
          for (int i = 0; i < LEVELS; i++) begin
            if (req_idx == IW'(i)) begin
              flags_next[i] = 1'b1;
            end
          end
        end
      end
      default: begin
        if (alarm && phase_r == PH_CLOSING) begin
          if (in_cmd == CMD_CLEAR) begin
            alarm_next   = 1'b0;
            blocked_next = 1'b0;
            tc_next      = 8'd0;
            pres_next    = PRES_NONE;
          end
        end else begin
          pres_next = in_cmd;
        end
      end
    endcase

    if (cmd.exec && need_scan) begin
      hi_ptr_next   = (car_idx < 0) ? '0 : car_idx;
      lo_ptr_next   = (car_idx > n_lv - ONE) ? n_lv - ONE : car_idx;
      hi_done_next  = 1'b0;
      lo_done_next  = 1'b0;
      hi_found_next = 1'b0;
      lo_found_next = 1'b0;
    end

    if (!cmd.exec) begin
      flags_next   = flags;
      floor_next   = floor_r;
      phase_next   = phase_r;
      blocked_next = blocked;
      alarm_next   = alarm;
      pres_next    = pres;
      tc_next      = tc;
      clr_en       = 1'b0;
    end

    // one level up and one level down per cycle
    if (cmd.scan_step) begin
      if (!hi_done) begin
        if (hi_ptr >= n_lv) begin
          hi_done_next = 1'b1;
        end else if (flags[hi_ptr[XW-1:0]]) begin
          hi_done_next  = 1'b1;
          hi_found_next = 1'b1;
        end else begin
          hi_ptr_next = hi_ptr + ONE;
        end
      end
      if (!lo_done) begin
        if (lo_ptr < 0) begin
          lo_done_next = 1'b1;
        end else if (flags[lo_ptr[XW-1:0]]) begin
          lo_done_next  = 1'b1;
          lo_found_next = 1'b1;
        end else begin
          lo_ptr_next = lo_ptr - ONE;
        end
      end
    end

    if (cmd.apply && (go_up || go_dn)) begin
      target_next = (go_up ? hi_ptr : lo_ptr) - base_x;
      dir_next    = go_up ? DIR_UP : DIR_DOWN;
      phase_next  = go_up ? PH_UP : PH_DOWN;
      tc_next     = 8'd0;
      // request at the current floor: arrive at once
      if ((go_up ? hi_ptr : lo_ptr) == car_idx) begin
        clr_en     = 1'b1;
        clr_idx    = car_idx;
        phase_next = PH_OPENING;
      end
    end

    if (clr_en && clr_idx >= 0 && clr_idx < LV) begin
      for (int i = 0; i < LEVELS; i++) begin
        if (clr_idx == IW'(i)) begin
          flags_next[i] = 1'b0;
        end
      end
    end

    lay_clear = cfg_we && (cfg_index == REG_ABOVE || cfg_index == REG_BASE);
    if (lay_clear) begin
      flags_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags    <= '0;
      floor_r  <= '0;
      target   <= '0;
      dir_r    <= DIR_STOP;
      phase_r  <= PH_OPEN;
      blocked  <= 1'b0;
      alarm    <= 1'b0;
      pres     <= PRES_NONE;
      tc       <= 8'd0;
      hi_ptr   <= '0;
      lo_ptr   <= '0;
      hi_done  <= 1'b0;
      lo_done  <= 1'b0;
      hi_found <= 1'b0;
      lo_found <= 1'b0;
    end else begin
      flags    <= flags_next;
      floor_r  <= floor_next;
      target   <= target_next;
      dir_r    <= dir_next;
      phase_r  <= phase_next;
      blocked  <= blocked_next;
      alarm    <= alarm_next;
      pres     <= pres_next;
      tc       <= tc_next;
      hi_ptr   <= hi_ptr_next;
      lo_ptr   <= lo_ptr_next;
      hi_done  <= hi_done_next;
      lo_done  <= lo_done_next;
      hi_found <= hi_found_next;
      lo_found <= lo_found_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      travel_ticks <= 4'd1;
      door_ticks   <= 4'd1;
      wait_ticks   <= 8'd2;
      above        <= 5'd20;
      base         <= 3'd5;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TRAVEL:  travel_ticks <= cfg_data[3:0];
        REG_DOOR:    door_ticks   <= cfg_data[3:0];
        REG_BLOCKED: wait_ticks   <= cfg_data;
        REG_ABOVE:   above        <= cfg_data[4:0];
        REG_BASE:    base         <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  assign stat.need_scan = need_scan;
  assign stat.scan_done = hi_done && lo_done;

  assign s_floor   = floor_r[FLOOR_W-1:0];
  assign s_phase   = phase_r;
  assign s_dir     = dir_r;
  assign s_alarm   = alarm;
  assign s_blocked = blocked;
  assign s_flags   = flags;

endmodule

>>> design/elc_out.sv
// result register of the elevator car controller, valid/ready toward the sink
// depends on elc_pkg
`timescale 1ns / 1ps

module elc_out #(
  parameter int LEVELS = 26
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               load,
  output logic                               can_load,
  input  logic signed [elc_pkg::FLOOR_W-1:0] d_floor,
  input  logic [elc_pkg::PHASE_W-1:0]        d_phase,
  input  logic [elc_pkg::DIR_W-1:0]          d_dir,
  input  logic                               d_alarm,
  input  logic                               d_blocked,
  input  logic [LEVELS-1:0]                  d_flags,
  output logic                               valid,
  input  logic                               ready,
  output logic signed [elc_pkg::FLOOR_W-1:0] q_floor,
  output logic [elc_pkg::PHASE_W-1:0]        q_phase,
  output logic [elc_pkg::DIR_W-1:0]          q_dir,
  output logic                               q_alarm,
  output logic                               q_blocked,
  output logic [LEVELS-1:0]                  q_flags
);
  import elc_pkg::*;

  assign can_load = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q_floor   <= d_floor;
      q_phase   <= d_phase;
      q_dir     <= d_dir;
      q_alarm   <= d_alarm;
      q_blocked <= d_blocked;
      q_flags   <= d_flags;
    end
  end

endmodule

>>> design/elevator_look_controller_top.sv
// elevator car controller with LOOK floor selection
// flow: an accepted request is pushed into the result register; a tick that selects the
//   next floor first runs the level scan, which walks one level up and one down per cycle
// one request in flight: the sequencer takes no new request until its result is pushed,
//   and the push waits while the result register holds an untaken result
// reset: synchronous, clears car state and loads register defaults; no memory sweep
`timescale 1ns / 1ps
`include "elevator_look_controller_top_assert.svh"

module elevator_look_controller_top #(
  parameter int LEVELS = 26
) (
  input  logic                               clk,
  input  logic                               rst,
  // request channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [elc_pkg::CMD_W-1:0]          cmd,
  input  logic signed [elc_pkg::FLOOR_W-1:0] request_floor,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [elc_pkg::FLOOR_W-1:0] car_floor,
  output logic [elc_pkg::PHASE_W-1:0]        phase,
  output logic [elc_pkg::DIR_W-1:0]          travel_dir,
  output logic                               alarm_on,
  output logic                               door_blocked,
  output logic [LEVELS-1:0]                  pending_requests,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [elc_pkg::CFG_IW-1:0]         cfg_index,
  input  logic [elc_pkg::CFG_DW-1:0]         cfg_data
);
  import elc_pkg::*;

  // index width: covers car index, level count and the pointer stepping past either end
  localparam int IW = $clog2(LEVELS + 40) + 1;

  elc_cmd_t  ctl_cmd;
  elc_stat_t dp_stat;
  logic      out_can_load;

  logic signed [FLOOR_W-1:0] s_floor;
  logic [PHASE_W-1:0]        s_phase;
  logic [DIR_W-1:0]          s_dir;
  logic                      s_alarm;
  logic                      s_blocked;
  logic [LEVELS-1:0]         s_flags;

  // register writes land at once; the host must write only while the car is idle, the block itself does not enforce it
  assign cfg_ready = 1'b1;

  // sequencer: accept a request, run the floor scan if needed, push the result
  elc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_can_load (out_can_load),
    .stat         (dp_stat),
    .cmd          (ctl_cmd)
  );

  // car state, door timers, register file and the two-way LOOK scan
  elc_dp #(
    .LEVELS (LEVELS),
    .IW     (IW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (ctl_cmd),
    .stat      (dp_stat),
    .in_cmd    (cmd),
    .in_floor  (request_floor),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_floor   (s_floor),
    .s_phase   (s_phase),
    .s_dir     (s_dir),
    .s_alarm   (s_alarm),
    .s_blocked (s_blocked),
    .s_flags   (s_flags)
  );

  // output register lets the next request in while a result waits
  elc_out #(
    .LEVELS (LEVELS)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (ctl_cmd.load_out),
    .can_load  (out_can_load),
    .d_floor   (s_floor),
    .d_phase   (s_phase),
    .d_dir     (s_dir),
    .d_alarm   (s_alarm),
    .d_blocked (s_blocked),
    .d_flags   (s_flags),
    .valid     (out_valid),
    .ready     (out_ready),
    .q_floor   (car_floor),
    .q_phase   (phase),
    .q_dir     (travel_dir),
    .q_alarm   (alarm_on),
    .q_blocked (door_blocked),
    .q_flags   (pending_requests)
  );

  // one request in flight at a time
  `ELC_ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready, "request accepted while busy")
  // the alarm only stands during a blocked close
  `ELC_ASSERT_IMPL(a_alarm_blocked, clk, rst, out_valid && alarm_on, door_blocked && phase == PH_CLOSING, "alarm outside blocked closing")
  // moving phases agree with the travel direction
  `ELC_ASSERT_IMPL(a_up_dir, clk, rst, out_valid && phase == PH_UP, travel_dir == DIR_UP, "moving up with wrong direction")
  `ELC_ASSERT_IMPL(a_down_dir, clk, rst, out_valid && phase == PH_DOWN, travel_dir == DIR_DOWN, "moving down with wrong direction")

endmodule

>>> dv/testbench.sv
// self-checking bench for the elevator car controller with LOOK floor selection
// depends on elc_pkg and elevator_look_controller_top; the expected car status is
// worked out here from a copy of the car state and compared result by result
`timescale 1ns / 1ps

module testbench;
  import elc_pkg::*;

  localparam int LEVELS          = 26;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 155;
  localparam int DIRECTED_ROWS   = 25;
  localparam int SETTLE_CYCLES   = 64;
  // no register lives at this index, a write to it must change nothing
  localparam logic [CFG_IW-1:0] REG_UNUSED = 3'd7;

  // one car status as seen on the result port
  typedef struct packed {
    logic [FLOOR_W-1:0] floor_no;
    logic [PHASE_W-1:0] phase_no;
    logic [DIR_W-1:0]   dir_no;
    logic               alarm;
    logic               blocked;
    logic [LEVELS-1:0]  pending;
  } car_status_t;

  // one row of the directed stimulus, want is used only when typed is set
  typedef struct {
    logic [CMD_W-1:0]          op;
    logic signed [FLOOR_W-1:0] flr;
    bit                        typed;
    car_status_t               want;
  } stim_row_t;

  localparam car_status_t NO_STATUS   = '0;
  // car parked at ground, door open, top floor requested
  localparam car_status_t TOP_WAITING = '{6'd0, PH_OPEN, DIR_STOP, 1'b0, 1'b0, 26'h2000000};
  // same with the lowest basement requested as well
  localparam car_status_t BOTH_ENDS   = '{6'd0, PH_OPEN, DIR_STOP, 1'b0, 1'b0, 26'h2000001};

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [CMD_W-1:0]          cmd = CMD_TICK;
  logic signed [FLOOR_W-1:0] request_floor = '0;

  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [FLOOR_W-1:0] car_floor;
  logic [PHASE_W-1:0]        phase;
  logic [DIR_W-1:0]          travel_dir;
  logic                      alarm_on;
  logic                      door_blocked;
  logic [LEVELS-1:0]         pending_requests;

  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IW-1:0]         cfg_index = REG_TRAVEL;
  logic [CFG_DW-1:0]         cfg_data = '0;

  elevator_look_controller_top #(
    .LEVELS(LEVELS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .request_floor(request_floor),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .car_floor(car_floor),
    .phase(phase),
    .travel_dir(travel_dir),
    .alarm_on(alarm_on),
    .door_blocked(door_blocked),
    .pending_requests(pending_requests),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // ---------------------------------------------------------------------------
  // shadow copy of the car: state and registers
  // ---------------------------------------------------------------------------
  logic [LEVELS-1:0]  car_pending;
  int                 car_pos;
  int                 car_dest;
  logic [DIR_W-1:0]   car_dir;
  logic [PHASE_W-1:0] car_phase;
  logic               door_block;
  logic               alarm_state;
  logic [CMD_W-1:0]   held_presence;
  int                 tick_cnt;

  int ticks_per_floor;
  int door_time;
  int block_wait;
  int above_cnt;
  int base_cnt;

  // expected car status, oldest first
  car_status_t car_status_due[$];
  int          mismatch_count = 0;

  // idle rates in percent of cycles
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;

  function automatic void reset_car();
    car_pending     = '0;
    car_pos         = 0;
    car_dest        = 0;
    car_dir         = DIR_STOP;
    car_phase       = PH_OPEN;
    door_block      = 1'b0;
    alarm_state     = 1'b0;
    held_presence   = PRES_NONE;
    tick_cnt        = 0;
    ticks_per_floor = 1;
    door_time       = 1;
    block_wait      = 2;
    above_cnt       = 20;
    base_cnt        = 5;
  endfunction

  // levels in the building, capped at what the flag vector holds
  function automatic int level_total();
    int n;
    n = above_cnt + 1 + base_cnt;
    return (n > LEVELS) ? LEVELS : n;
  endfunction

  function automatic void count_tick();
    if (tick_cnt < 255) tick_cnt++;
  endfunction

  // at the destination: drop its flag and start opening the door
  function automatic void arrive_if_there();
    int idx;
    if (car_pos == car_dest) begin
      idx = car_pos + base_cnt;
      if (idx >= 0 && idx < LEVELS) car_pending[idx] = 1'b0;
      car_phase = PH_OPENING;
      tick_cnt  = 0;
    end
  endfunction

  function automatic void set_course(input int dest, input logic [DIR_W-1:0] d);
    car_dest  = dest;
    car_dir   = d;
    car_phase = (d == DIR_UP) ? PH_UP : PH_DOWN;
    tick_cnt  = 0;
    arrive_if_there();
  endfunction

  // LOOK: keep going while requests lie ahead, else turn; with no direction yet the
  // nearest request wins and a tie goes up
  function automatic void look_select();
    int n, idx, i, start, hi, lo;
    bit has_hi, has_lo;
    n = level_total();
    idx = car_pos + base_cnt;
    has_hi = 1'b0;
    has_lo = 1'b0;
    hi = 0;
    lo = 0;
    // searches are clipped to the valid levels when the car sits outside them
    start = (idx < 0) ? 0 : idx;
    for (i = start; i < n && !has_hi; i++) begin
      if (car_pending[i]) begin
        has_hi = 1'b1;
        hi = i - base_cnt;
      end
    end
    start = (idx > n - 1) ? n - 1 : idx;
    for (i = start; i >= 0 && !has_lo; i--) begin
      if (car_pending[i]) begin
        has_lo = 1'b1;
        lo = i - base_cnt;
      end
    end
    if (car_dir == DIR_UP) begin
      if (has_hi) set_course(hi, DIR_UP);
      else if (has_lo) set_course(lo, DIR_DOWN);
      else car_phase = PH_CLOSED;
    end else if (car_dir == DIR_DOWN) begin
      if (has_lo) set_course(lo, DIR_DOWN);
      else if (has_hi) set_course(hi, DIR_UP);
      else car_phase = PH_CLOSED;
    end else begin
      if (has_hi && has_lo) begin
        if (hi - car_pos <= car_pos - lo) set_course(hi, DIR_UP);
        else set_course(lo, DIR_DOWN);
      end else if (has_hi) begin
        set_course(hi, DIR_UP);
      end else if (has_lo) begin
        set_course(lo, DIR_DOWN);
      end else begin
        car_phase = PH_CLOSED;
      end
    end
  endfunction

  // a person held from before closing blocks the door
  function automatic void door_close_start();
    car_phase     = PH_CLOSING;
    tick_cnt      = 0;
    door_block    = (held_presence == CMD_SOMEONE);
    alarm_state   = 1'b0;
    held_presence = PRES_NONE;
  endfunction

  function automatic void tick_car();
    case (car_phase)
      PH_CLOSING: begin
        if (!alarm_state) begin
          count_tick();
          if (door_block) begin
            // wait expired: clear resumes, someone raises the alarm, nothing waits again
            if (tick_cnt >= block_wait) begin
              tick_cnt = 0;
              if (held_presence == CMD_CLEAR) begin
                door_block    = 1'b0;
                held_presence = PRES_NONE;
              end else if (held_presence == CMD_SOMEONE) begin
                alarm_state   = 1'b1;
                held_presence = PRES_NONE;
              end
            end
          end else if (tick_cnt >= door_time) begin
            car_phase = PH_CLOSED;
            tick_cnt  = 0;
            look_select();
          end
        end
      end
      PH_CLOSED: begin
        if (car_pending != '0) begin
          look_select();
        end else begin
          car_phase = PH_OPENING;
          tick_cnt  = 0;
        end
      end
      PH_OPENING: begin
        count_tick();
        if (tick_cnt >= door_time) begin
          car_phase = PH_OPEN;
          tick_cnt  = 0;
        end
      end
      PH_UP, PH_DOWN: begin
        arrive_if_there();
        if (car_phase == PH_UP || car_phase == PH_DOWN) begin
          count_tick();
          if (tick_cnt >= ticks_per_floor) begin
            tick_cnt = 0;
            if (car_pos < car_dest) car_pos++;
            else car_pos--;
            arrive_if_there();
          end
        end
      end
      default: begin
        car_phase = PH_OPEN;
        if (car_pending != '0) begin
          count_tick();
          if (tick_cnt >= door_time) door_close_start();
        end else begin
          tick_cnt = 0;
        end
      end
    endcase
  endfunction

  // applies one request to the shadow car and returns the status it leaves
  function automatic car_status_t advance_car(input logic [CMD_W-1:0] c,
                                              input logic signed [FLOOR_W-1:0] flr);
    car_status_t s;
    int idx;
    if (c == CMD_TICK) begin
      tick_car();
    end else if (c == CMD_REQ) begin
      idx = int'(flr) + base_cnt;
      if (idx >= 0 && idx < level_total()) car_pending[idx] = 1'b1;
    end else if (alarm_state && car_phase == PH_CLOSING) begin
      // during the alarm only a clear doorway counts, and it resumes closing at once
      if (c == CMD_CLEAR) begin
        alarm_state   = 1'b0;
        door_block    = 1'b0;
        tick_cnt      = 0;
        held_presence = PRES_NONE;
      end
    end else begin
      held_presence = c;
    end
    s.floor_no = car_pos[FLOOR_W-1:0];
    s.phase_no = car_phase;
    s.dir_no   = car_dir;
    s.alarm    = alarm_state;
    s.blocked  = door_block;
    s.pending  = car_pending;
    return s;
  endfunction

  // register write as the block sees it; a layout change wipes the request flags
  function automatic void apply_register(input logic [CFG_IW-1:0] idx,
                                         input logic [CFG_DW-1:0] val);
    case (idx)
      REG_TRAVEL:  ticks_per_floor = int'(val[3:0]);
      REG_DOOR:    door_time = int'(val[3:0]);
      REG_BLOCKED: block_wait = int'(val);
      REG_ABOVE: begin
        above_cnt   = int'(val[4:0]);
        car_pending = '0;
      end
      REG_BASE: begin
        base_cnt    = int'(val[2:0]);
        car_pending = '0;
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // directed rows: the first ones are read straight off the reset state, the
  // rest walk blocking, alarm, nearest-first selection and a same-floor request
  // ---------------------------------------------------------------------------
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{CMD_REQ,     6'sd20,  1'b1, TOP_WAITING},  // top floor
    '{CMD_REQ,     -6'sd5,  1'b1, BOTH_ENDS},    // lowest basement
    '{CMD_REQ,     6'sd21,  1'b1, BOTH_ENDS},    // one above the top, ignored
    '{CMD_REQ,     -6'sd6,  1'b1, BOTH_ENDS},    // one below the bottom, ignored
    '{CMD_REQ,     6'sd31,  1'b1, BOTH_ENDS},    // field maximum, ignored
    '{CMD_REQ,     -6'sd32, 1'b1, BOTH_ENDS},    // field minimum, ignored
    '{CMD_SOMEONE, 6'sd0,   1'b1, BOTH_ENDS},    // held while the door is open
    '{CMD_TICK,    6'sd0,   1'b0, NO_STATUS},    // closing starts blocked
    '{CMD_TICK,    6'sd0,   1'b0, NO_STATUS},
    '{CMD_SOMEONE, 6'sd0,   1'b0, NO_STATUS},
    '{CMD_TICK,    6'sd0,   1'b0, NO_STATUS},    // wait expires, person still there
    '{CMD_TICK,    6'sd0,   1'b0, NO_STATUS},    // alarm holds
    '{CMD_SOMEONE, 6'sd0,   1'b0, NO_STATUS},    // dropped during the alarm
    '{CMD_CLEAR,   6'sd0,   1'b0, NO_STATUS},    // alarm off, closing resumes
    '{CMD_TICK,    6'sd0,   1'b0, NO_STATUS},    // closed, nearest request is below
    '{CMD_CLEAR,   6'sd0,   1'b0, NO_STATUS},    // presence while moving is only held
    '{CMD_TICK,    6'sd0,   1'b0, NO_STATUS},
    '{CMD_TICK,    6'sd0,   1'b0, NO_STATUS},
    '{CMD_TICK,    6'sd0,   1'b0, NO_STATUS},
    '{CMD_TICK,    6'sd0,   1'b0, NO_STATUS},
    '{CMD_TICK,    6'sd0,   1'b0, NO_STATUS},
    '{CMD_REQ,     -6'sd5,  1'b0, NO_STATUS},    // request at the floor the car is on
    '{CMD_TICK,    6'sd0,   1'b0, NO_STATUS},
    '{CMD_TICK,    6'sd0,   1'b0, NO_STATUS},
    '{CMD_TICK,    6'sd0,   1'b0, NO_STATUS}
  };

  // ---------------------------------------------------------------------------
  // clock, receiver stalls and the run timeout
  // ---------------------------------------------------------------------------
  initial begin
    forever #2 clk = ~clk;
  end

  // receiver takes a result in all but recv_stall_pct percent of cycles
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // generous bound on the slowest correct run
  initial begin
    #2000000;
    $display("testbench failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result checking: every taken result against the oldest expected status
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    car_status_t want;
    if (!rst && out_valid && out_ready) begin
      if (car_status_due.size() == 0) begin
        $display("%0t: unexpected result, floor %h phase %h", $time, car_floor, phase);
        mismatch_count++;
      end else begin
        want = car_status_due.pop_front();
        check_field("car_floor", 32'(want.floor_no), 32'($unsigned(car_floor)));
        check_field("phase", 32'(want.phase_no), 32'(phase));
        check_field("travel_dir", 32'(want.dir_no), 32'(travel_dir));
        check_field("alarm_on", 32'(want.alarm), 32'(alarm_on));
        check_field("door_blocked", 32'(want.blocked), 32'(door_blocked));
        check_field("pending_requests", 32'(want.pending), 32'(pending_requests));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request driver
  // ---------------------------------------------------------------------------
  // valid stays high from one request to the next unless an idle cycle is drawn,
  // so it is never lowered and raised in the same step
  task automatic send_request(input logic [CMD_W-1:0] c,
                              input logic signed [FLOOR_W-1:0] flr,
                              input bit typed, input car_status_t want);
    car_status_t predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    cmd           <= c;
    request_floor <= flr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // accepted at this edge
    predicted = advance_car(c, flr);
    car_status_due.push_back(typed ? want : predicted);
  endtask

  // mostly ticks and in-range floor requests, with presence events and some
  // arbitrary floor codes mixed in
  task automatic send_random();
    int roll;
    logic [CMD_W-1:0] c;
    logic signed [FLOOR_W-1:0] flr;
    roll = $urandom_range(99);
    flr = FLOOR_W'($urandom_range(63));
    if (roll < 55) begin
      c = CMD_TICK;
    end else if (roll < 80) begin
      c = CMD_REQ;
      if (roll < 77) flr = FLOOR_W'(int'($urandom_range(level_total() - 1)) - base_cnt);
    end else if (roll < 90) begin
      c = CMD_SOMEONE;
    end else begin
      c = CMD_CLEAR;
    end
    send_request(c, flr, 1'b0, NO_STATUS);
  endtask

  // sender holds off until every expected status has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (car_status_due.size() != 0) @(posedge clk);
  endtask

  // cfg valid is kept high across a batch and lowered by the caller
  task automatic write_register(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_register(idx, val);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int r, p, k;
    reset_car();
    rst <= 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed part on reset settings, no idling
    for (r = 0; r < DIRECTED_ROWS; r++) begin
      send_request(directed_rows[r].op, directed_rows[r].flr,
                   directed_rows[r].typed, directed_rows[r].want);
    end

    for (p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        // block is idle once every status is back; only then are registers touched
        drain_results();
        case (p)
          1: begin
            // slow timing and the longest blocked wait on the full building
            write_register(REG_TRAVEL, 8'd9);
            write_register(REG_DOOR, 8'd9);
            write_register(REG_BLOCKED, 8'd255);
            write_register(REG_ABOVE, 8'd20);
            write_register(REG_BASE, 8'd5);
          end
          2: begin
            // fastest timing on a two-level building, car likely left outside it
            write_register(REG_TRAVEL, 8'd1);
            write_register(REG_DOOR, 8'd1);
            write_register(REG_BLOCKED, 8'd1);
            write_register(REG_ABOVE, 8'd1);
            write_register(REG_BASE, 8'd0);
          end
          3: begin
            // zero timing acts as one, layout larger than the flag vector
            write_register(REG_TRAVEL, 8'd0);
            write_register(REG_DOOR, 8'd0);
            write_register(REG_BLOCKED, 8'd0);
            write_register(REG_BASE, 8'd7);
            write_register(REG_ABOVE, 8'd31);
            write_register(REG_UNUSED, 8'hA5);
          end
          default: begin
            write_register(REG_BASE, 8'($urandom_range(5)));
            write_register(REG_TRAVEL, 8'($urandom_range(9, 1)));
            write_register(REG_DOOR, 8'($urandom_range(9, 1)));
            write_register(REG_BLOCKED, 8'($urandom_range(12, 1)));
            write_register(REG_ABOVE, 8'($urandom_range(20, 1)));
          end
        endcase
        cfg_valid <= 1'b0;
      end

      // idle mix: none, sender, receiver, both
      case (p % 4)
        0: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 0;
        end
        1: begin
          sender_idle_pct = 83;
          recv_stall_pct  = 0;
        end
        2: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 83;
        end
        default: begin
          sender_idle_pct = 20;
          recv_stall_pct  = 20;
        end
      endcase

      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        send_random();
      end
    end

    // everything sent: wait for the last status, then let stray results show up
    drain_results();
    recv_stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && car_status_due.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
